[sv/rhsl_pkg.sv]
// ----------------------------------------------------------------------------
// rhsl_pkg
// Shared widths and constants for the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rhsl_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned HueW     = 15;
  localparam int unsigned SatW     = 16;
  localparam int unsigned LigW     = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // quotient bits produced by every divider, one per stage
  localparam int unsigned QuoW = 16;

  // hue = round(31415*4096*num / (30000*d)), done as floor((2N+D)/(2D))
  localparam int unsigned HueNumW = 39;
  localparam int unsigned HueDenW = 24;
  localparam logic [27:0] HueScale = 28'd128675840;  // 31415*4096
  localparam logic [15:0] HueDiv2  = 16'd60000;      // 2*30000

  // saturation = floor((131070*d + den) / (2*den))
  localparam int unsigned SatNumW = 25;
  localparam int unsigned SatDenW = 10;
  localparam logic [16:0] SatScale = 17'd131070;

  // lightness = round(65535*s/510) = (257*s + 1) >> 1, no divider needed

  typedef struct packed {
    logic [HueNumW-1:0] hue_num;
    logic [HueDenW-1:0] hue_den;
    logic [SatNumW-1:0] sat_num;
    logic [SatDenW-1:0] sat_den;
    logic [LigW-1:0]    lig;
    logic               grey;
  } rhsl_front_t;

endpackage

[sv/rhsl_front.sv]
// ----------------------------------------------------------------------------
// rhsl_front
// First two stages: max/min and hue sector, then dividend/divisor set-up.
// ----------------------------------------------------------------------------
module rhsl_front (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rhsl_pkg::ChanW-1:0]    red_i,
  input  logic [rhsl_pkg::ChanW-1:0]    green_i,
  input  logic [rhsl_pkg::ChanW-1:0]    blue_i,
  output rhsl_pkg::rhsl_front_t         front_o
);
  import rhsl_pkg::*;

  rhsl_front_t front_d, front_q;
  logic [7:0]  mx, mn;
  logic [8:0]  s;
  logic signed [11:0] diff;
  logic [16:0] lig_sum;
  logic [7:0]  span_d, span_q;
  logic [8:0]  den_d, den_q;
  logic [10:0] num_d, num_q;
  logic [LigW-1:0] lig_d, lig_q;

  // stage 1: extremes, sector numerator, saturation divisor, lightness
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    span_d = mx - mn;
    s      = {1'b0, mx} + {1'b0, mn};
    den_d  = (s <= 9'd255) ? s : (9'd510 - s);

    // red first, then green, then blue
    if (mx == red_i) begin
      diff = $signed({4'b0, green_i}) - $signed({4'b0, blue_i});
      if (diff < 0) diff = diff + $signed({1'b0, 11'(6 * span_d)});
    end else if (mx == green_i) begin
      diff = $signed({4'b0, blue_i}) - $signed({4'b0, red_i})
           + $signed({3'b0, span_d, 1'b0});
    end else begin
      diff = $signed({4'b0, red_i}) - $signed({4'b0, green_i})
           + $signed({2'b0, span_d, 2'b0});
    end
    num_d = diff[10:0];

    // 257*s + 1, halved
    lig_sum = {s, 8'b0} + 17'(s) + 17'd1;
    lig_d   = lig_sum[16:1];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      span_q <= span_d;
      den_q  <= den_d;
      num_q  <= num_d;
      lig_q  <= lig_d;
    end
  end

  // stage 2: scaled dividends and divisors
  always_comb begin
    front_d.hue_num = HueNumW'(HueScale * num_q) * 2 + HueNumW'(HueDiv2 * span_q) / 2;
    front_d.hue_den = HueDenW'(HueDiv2 * span_q);
    front_d.sat_num = SatNumW'(SatScale * span_q) + SatNumW'(den_q);
    front_d.sat_den = {den_q, 1'b0};
    front_d.lig     = lig_q;
    front_d.grey    = (span_q == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) front_q <= front_d;
  end

  assign front_o = front_q;

endmodule

[sv/rhsl_div.sv]
// ----------------------------------------------------------------------------
// rhsl_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhsl_div #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 10,
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,  // must be below den_i << QW
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW], rem_d [QW];
  logic [QW-1:0] xlo_q [QW], xlo_d [QW];
  logic [QW-1:0] quo_q [QW], quo_d [QW];
  logic [DW-1:0] y_q   [QW], y_d   [QW];

  always_comb begin
    logic [DW-1:0] rin;
    logic [QW-1:0] xin, qin;
    logic [DW-1:0] yin;
    logic [DW:0]   t;
    logic          qbit;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rin = DW'(num_i >> QW);
        xin = num_i[QW-1:0];
        qin = '0;
        yin = den_i;
      end else begin
        rin = rem_q[i-1];
        xin = xlo_q[i-1];
        qin = quo_q[i-1];
        yin = y_q[i-1];
      end
      t = {rin, xin[QW-1]};
      qbit = (t >= {1'b0, yin});
      rem_d[i] = qbit ? DW'(t - {1'b0, yin}) : DW'(t);
      xlo_d[i] = xin << 1;
      quo_d[i] = {qin[QW-2:0], qbit};
      y_d[i]   = yin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      xlo_q <= xlo_d;
      quo_q <= quo_d;
      y_q   <= y_d;
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[sv/rgb_to_hsl_pixel_converter.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_converter
// Streaming RGB888 to HSL converter, one pixel per clock unless the output stalls.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: red[7:0], green[15:8], blue[23:16]
// m_axis    out  tdata: hue[14:0], saturation[30:15], lightness[46:31], pad
//
// Accepts one word per clock unless the output stalls; two set-up stages
// (extremes and sector, then scaling), then 16 stages of restoring division
// (one quotient bit each) for hue and saturation in parallel. Lightness is
// a closed form from the first stage, carried alongside the dividers.
// Reset clears only the valid bits; data registers are left as they are.
// A stall at the output freezes the whole pipeline; s_axis_tready falls
// only while a finished word waits at the output.
// ----------------------------------------------------------------------------
module rgb_to_hsl_pixel_converter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rhsl_pkg::InDataW-1:0]    s_axis_tdata,   // red, green, blue
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rhsl_pkg::OutDataW-1:0]   m_axis_tdata    // hue, sat, light
);
  import rhsl_pkg::*;

  localparam int unsigned Depth = QuoW + 2;

  logic              adv;
  logic [Depth-1:0]  vld_q, vld_d;
  logic [QuoW-1:0]   grey_q, grey_d;   // grey flag beside the divider stages
  logic [LigW-1:0]   lig_q [QuoW];     // lightness beside the divider stages
  rhsl_front_t       front;
  logic [QuoW-1:0]   hue_quo, sat_quo;

  // whole pipe moves unless the output word is held
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[Depth-1];

  rhsl_front u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .front_o (front)
  );

  rhsl_div #(.NW(HueNumW), .DW(HueDenW), .QW(QuoW)) u_hue_div (
    .clk_i (clk_i), .en_i (adv),
    .num_i (front.hue_num), .den_i (front.hue_den), .quo_o (hue_quo)
  );

  rhsl_div #(.NW(SatNumW), .DW(SatDenW), .QW(QuoW)) u_sat_div (
    .clk_i (clk_i), .en_i (adv),
    .num_i (front.sat_num), .den_i (front.sat_den), .quo_o (sat_quo)
  );

  assign vld_d  = {vld_q[Depth-2:0], s_axis_tvalid};
  assign grey_d = {grey_q[QuoW-2:0], front.grey};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      grey_q   <= grey_d;
      lig_q[0] <= front.lig;
      for (int i = 1; i < QuoW; i++) lig_q[i] <= lig_q[i-1];
    end
  end

  // grey pixel: hue and saturation forced to zero (divisor may be zero)
  assign m_axis_tdata = {1'b0,
                         lig_q[QuoW-1],
                         grey_q[QuoW-1] ? {SatW{1'b0}} : sat_quo,
                         grey_q[QuoW-1] ? {HueW{1'b0}} : hue_quo[HueW-1:0]};

endmodule

[sv/rhsl_checker.sv]
// ----------------------------------------------------------------------------
// rhsl_checker
// Port-level checks for the RGB to HSL converter.
// ----------------------------------------------------------------------------
module rhsl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rhsl_pkg::OutDataW-1:0]   m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word dropped or changed under stall");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_hue_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:0] <= 15'd25735)
    else $error("hue out of range");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("pad bit set");

endmodule

bind rgb_to_hsl_pixel_converter rhsl_checker u_rhsl_checker (.*);
